FILE: rtl/rmt_pkg.sv
`default_nettype none
package rmt_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 20;

    // Operation applied to every cell of a sorted chain together
    typedef enum logic [1:0] {
        OP_HOLD   = 2'b00,
        OP_INSERT = 2'b01,  // place a value, chain grows by one
        OP_POPINS = 2'b10   // drop the head and place a value, length unchanged
    } chain_op_t;

endpackage
`default_nettype wire

FILE: rtl/running_median_tracker.sv
// Running median over every sample seen since reset, up to CAPACITY samples.
// Input channel (in_valid/in_ready) carries one sample_value per beat. Output
// channel (out_valid/out_ready) returns one beat per input beat: the floor of
// the median of all kept samples, the count kept and an overflow flag.
// Storage is two rows of compare-and-shift cells meeting at the median: the
// lower half sorted downward from its head, the upper half upward. Each
// accepted sample below capacity is inserted into one row, or a head is handed
// across and the sample re-inserted; the median is read from the heads.
// An accepted beat updates the rows and sets calc_reg; calc_reg then loads
// the median from the heads into the output register and raises out_valid.
// A new sample is not taken while calc_reg is set, that is until the heads of
// the previous update have been read into the output register.
// A stalled receiver holds the result in the output register; a new sample is
// taken in the cycle the held result is taken, not earlier.
// When CAPACITY samples are stored further samples are dropped, overflow_flag
// is set and the median of the kept samples is returned.
// Reset empties both rows and clears the count; no clearing pass is needed.
`default_nettype none
module running_median_tracker #(
    parameter int CAPACITY    = rmt_pkg::CAPACITY_DEF,
    parameter int SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF,
    localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] sample_value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SAMPLE_BITS-1:0]      median_value,
    output logic [CNT_W-1:0]            stored_count,
    output logic                        overflow_flag
);

    localparam int LO_DEPTH = (CAPACITY + 1) / 2;
    localparam int HI_DEPTH = CAPACITY / 2;

    rmt_pkg::chain_op_t lo_op;
    rmt_pkg::chain_op_t hi_op;
    logic [SAMPLE_BITS-1:0] lo_ins;
    logic [SAMPLE_BITS-1:0] hi_ins;
    logic                   lo_head_occ;
    logic [SAMPLE_BITS-1:0] lo_head_inv;
    logic                   hi_head_occ;
    logic [SAMPLE_BITS-1:0] hi_head;
    logic [SAMPLE_BITS-1:0] lo_head;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   calc_reg;
    logic                   calc_next;
    logic                   drop_reg;
    logic                   drop_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] median_reg;
    logic [CNT_W-1:0]       stored_reg;
    logic                   overflow_reg;

    logic                   accept;
    logic                   full;
    logic [SAMPLE_BITS:0]   head_sum;
    logic [SAMPLE_BITS-1:0] median_comb;

    assign accept  = in_valid && in_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign lo_head = ~lo_head_inv;

    // Lower half is kept bit-inverted so both rows sort upward
    always_comb
    begin
        lo_op  = rmt_pkg::OP_HOLD;
        hi_op  = rmt_pkg::OP_HOLD;
        lo_ins = ~sample_value;
        hi_ins = sample_value;
        if (accept && !full)
        begin
            if (!count_reg[0])
            begin
                // Even count: lower half grows by one
                if (!hi_head_occ || (sample_value <= hi_head))
                begin
                    lo_op = rmt_pkg::OP_INSERT;
                end
                else
                begin
                    lo_op  = rmt_pkg::OP_INSERT;
                    lo_ins = ~hi_head;
                    hi_op  = rmt_pkg::OP_POPINS;
                end
            end
            else
            begin
                // Odd count: upper half grows by one
                if (sample_value >= lo_head)
                begin
                    hi_op = rmt_pkg::OP_INSERT;
                end
                else
                begin
                    hi_op  = rmt_pkg::OP_INSERT;
                    hi_ins = lo_head;
                    lo_op  = rmt_pkg::OP_POPINS;
                end
            end
        end
    end

    rmt_chain #(
        .W     (SAMPLE_BITS),
        .DEPTH (LO_DEPTH)
    ) u_lo_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (lo_op),
        .ins_val  (lo_ins),
        .head_occ (lo_head_occ),
        .head_val (lo_head_inv)
    );

    rmt_chain #(
        .W     (SAMPLE_BITS),
        .DEPTH (HI_DEPTH)
    ) u_hi_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (hi_op),
        .ins_val  (hi_ins),
        .head_occ (hi_head_occ),
        .head_val (hi_head)
    );

    assign head_sum    = {1'b0, lo_head} + {1'b0, hi_head};
    assign median_comb = count_reg[0] ? lo_head : head_sum[SAMPLE_BITS:1];

    always_comb
    begin
        count_next     = count_reg;
        drop_next      = drop_reg;
        calc_next      = calc_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            calc_next = 1'b1;
            drop_next = full;
            if (!full)
                count_next = count_reg + CNT_W'(1);
        end
        if (calc_reg)
        begin
            calc_next      = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            calc_reg      <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            calc_reg      <= calc_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_reg)
        begin
            median_reg   <= median_comb;
            stored_reg   <= count_reg;
            overflow_reg <= drop_reg;
        end
    end

    assign in_ready      = !calc_reg && (!out_valid_reg || out_ready);
    assign out_valid     = out_valid_reg;
    assign median_value  = median_reg;
    assign stored_count  = stored_reg;
    assign overflow_flag = overflow_reg;

    // Head of the median computation always loads the output register
    a_calc_loads: assert property (@(posedge clk) disable iff (!rst_n)
        calc_reg |=> out_valid_reg)
        else $error("median computed but no result presented");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow_flag) |-> (stored_count == CNT_W'(CAPACITY)))
        else $error("overflow reported below capacity");

    a_lo_head: assert property (@(posedge clk) disable iff (!rst_n)
        lo_head_occ == (count_reg != '0))
        else $error("lower row head out of step with count");

    a_hi_head: assert property (@(posedge clk) disable iff (!rst_n)
        hi_head_occ == (count_reg > CNT_W'(1)))
        else $error("upper row head out of step with count");

endmodule
`default_nettype wire

FILE: rtl/rmt_cell.sv
`default_nettype none
module rmt_cell #(
    parameter int W     = rmt_pkg::SAMPLE_BITS_DEF,
    parameter bit FIRST = 1'b0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rmt_pkg::chain_op_t op,
    input  wire logic [W-1:0]      ins_val,
    input  wire logic              left_occ,
    input  wire logic [W-1:0]      left_val,
    input  wire logic              right_occ,
    input  wire logic [W-1:0]      right_val,
    output logic                   occ,
    output logic [W-1:0]           val
);

    logic         occ_reg;
    logic         occ_next;
    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;
    logic         a_occ;
    logic [W-1:0] a_val;
    logic         b_occ;
    logic [W-1:0] b_val;
    logic         prev_gt;

    always_comb
    begin
        // On insert the candidates are left and self; after a head pop they
        // slide one place toward the head, so self and right.
        if (op == rmt_pkg::OP_POPINS)
        begin
            a_occ = occ_reg;
            a_val = val_reg;
            b_occ = right_occ;
            b_val = right_val;
        end
        else
        begin
            a_occ = left_occ;
            a_val = left_val;
            b_occ = occ_reg;
            b_val = val_reg;
        end

        prev_gt = !FIRST && a_occ && (a_val > ins_val);

        if (prev_gt)
            val_next = a_val;
        else if (!b_occ || (b_val > ins_val))
            val_next = ins_val;
        else
            val_next = b_val;

        case (op)
            rmt_pkg::OP_INSERT: occ_next = occ_reg | (FIRST ? 1'b1 : left_occ);
            rmt_pkg::OP_POPINS: occ_next = occ_reg;
            rmt_pkg::OP_HOLD:   occ_next = occ_reg;
            default:            occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        if (op != rmt_pkg::OP_HOLD)
            val_reg <= val_next;
    end

    assign occ = occ_reg;
    assign val = val_reg;

endmodule
`default_nettype wire

FILE: rtl/rmt_chain.sv
`default_nettype none
module rmt_chain #(
    parameter int W     = rmt_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH = rmt_pkg::CAPACITY_DEF / 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rmt_pkg::chain_op_t op,
    input  wire logic [W-1:0]      ins_val,
    output logic                   head_occ,
    output logic [W-1:0]           head_val
);

    logic         occ_w [DEPTH];
    logic [W-1:0] val_w [DEPTH];

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        logic         l_occ;
        logic [W-1:0] l_val;
        logic         r_occ;
        logic [W-1:0] r_val;

        if (j == 0)
        begin : g_head
            assign l_occ = 1'b0;
            assign l_val = '0;
        end
        else
        begin : g_left
            assign l_occ = occ_w[j-1];
            assign l_val = val_w[j-1];
        end

        if (j == DEPTH - 1)
        begin : g_tail
            assign r_occ = 1'b0;
            assign r_val = '0;
        end
        else
        begin : g_right
            assign r_occ = occ_w[j+1];
            assign r_val = val_w[j+1];
        end

        rmt_cell #(
            .W     (W),
            .FIRST (j == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .ins_val   (ins_val),
            .left_occ  (l_occ),
            .left_val  (l_val),
            .right_occ (r_occ),
            .right_val (r_val),
            .occ       (occ_w[j]),
            .val       (val_w[j])
        );
    end

    assign head_occ = occ_w[0];
    assign head_val = val_w[0];

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
module testbench;

    localparam int SB        = rmt_pkg::SAMPLE_BITS_DEF;
    localparam int CAP       = rmt_pkg::CAPACITY_DEF;
    localparam int CNT_W     = $clog2(CAP + 1);
    localparam int RANDOM_N  = 400;
    localparam int IDLE_MAX  = 2000;
    localparam int SHOW_MAX  = 10;
    localparam int DIRECTED_N = 23;

    typedef struct packed {
        logic [SB-1:0]    median;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } median_result_t;

    typedef struct packed {
        logic [SB-1:0]  sample;
        logic           typed;
        median_result_t want;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [SB-1:0]    sample_value;
    logic             out_valid;
    logic             out_ready;
    logic [SB-1:0]    median_value;
    logic [CNT_W-1:0] stored_count;
    logic             overflow_flag;

    // Extremes and duplicates first; the first seven rows are easy to read by hand.
    stim_row_t directed_rows [DIRECTED_N] = '{
        '{20'hFFFFF, 1'b1, '{20'hFFFFF, 11'd1, 1'b0}},
        '{20'h00000, 1'b1, '{20'h7FFFF, 11'd2, 1'b0}},
        '{20'hFFFFF, 1'b1, '{20'hFFFFF, 11'd3, 1'b0}},
        '{20'h00000, 1'b1, '{20'h7FFFF, 11'd4, 1'b0}},
        '{20'h00000, 1'b1, '{20'h00000, 11'd5, 1'b0}},
        '{20'h00000, 1'b1, '{20'h00000, 11'd6, 1'b0}},
        '{20'hFFFFF, 1'b1, '{20'h00000, 11'd7, 1'b0}},
        '{20'h80000, 1'b0, '0},
        '{20'h7FFFF, 1'b0, '0},
        '{20'h00001, 1'b0, '0},
        '{20'hFFFFE, 1'b0, '0},
        '{20'h55555, 1'b0, '0},
        '{20'hAAAAA, 1'b0, '0},
        '{20'h12345, 1'b0, '0},
        '{20'h12345, 1'b0, '0},
        '{20'h12345, 1'b0, '0},
        '{20'h80000, 1'b0, '0},
        '{20'h00003, 1'b0, '0},
        '{20'hFFFFF, 1'b0, '0},
        '{20'h7FFFF, 1'b0, '0},
        '{20'h40000, 1'b0, '0},
        '{20'hC0000, 1'b0, '0},
        '{20'h00001, 1'b0, '0}
    };

    logic [SB-1:0]  sorted_store [CAP];
    int unsigned    kept_samples;
    median_result_t pending_medians [$];
    int             outstanding;
    int             in_beats;
    int             out_beats;
    int             mismatches;
    int             idle_cycles;
    logic           beat_typed;
    median_result_t beat_want;

    running_median_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .median_value  (median_value),
        .stored_count  (stored_count),
        .overflow_flag (overflow_flag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Insert after every equal sample, drop when full, then read the middle.
    function automatic median_result_t track_sample(input logic [SB-1:0] v);
        median_result_t r;
        int             pos;
        logic [SB:0]    sum;
        r.overflow = 1'b0;
        if (kept_samples < CAP)
        begin
            pos = kept_samples;
            while (pos > 0 && sorted_store[pos-1] > v)
            begin
                sorted_store[pos] = sorted_store[pos-1];
                pos--;
            end
            sorted_store[pos] = v;
            kept_samples++;
        end
        else
            r.overflow = 1'b1;
        if (kept_samples % 2 == 1)
            r.median = sorted_store[kept_samples/2];
        else
        begin
            sum = {1'b0, sorted_store[kept_samples/2-1]} + {1'b0, sorted_store[kept_samples/2]};
            r.median = sum[SB:1];
        end
        r.count = CNT_W'(kept_samples);
        return r;
    endfunction

    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_sample = SB'($urandom);
            4, 5:       pick_sample = SB'($urandom_range(0, 15));
            6:          pick_sample = $urandom_range(0, 1) ? '1 : '0;
            7:          pick_sample = SB'($urandom_range(0, 7)) << (SB - 3);
            default:    pick_sample = SB'($urandom_range(0, (1 << SB) - 1));
        endcase
    endfunction

    function automatic void note_mismatch(input median_result_t want, input median_result_t got);
        mismatches++;
        if (mismatches <= SHOW_MAX)
            $display("mismatch at beat %0d: median %h/%h count %0d/%0d overflow %b/%b",
                     out_beats, want.median, got.median, want.count, got.count,
                     want.overflow, got.overflow);
    endfunction

    always @(posedge clk)
    begin
        median_result_t want;
        median_result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                want = track_sample(sample_value);
                if (beat_typed)
                    want = beat_want;
                pending_medians.push_back(want);
                outstanding++;
                in_beats++;
            end
            if (out_valid && out_ready)
            begin
                got = '{median_value, stored_count, overflow_flag};
                if (pending_medians.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("unexpected result beat: median %h count %0d overflow %b",
                                 got.median, got.count, got.overflow);
                end
                else
                begin
                    want = pending_medians.pop_front();
                    outstanding--;
                    if (want !== got)
                        note_mismatch(want, got);
                end
                out_beats++;
            end
        end
    end

    // Abort if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    bit send_steady;

    // Hold the beat until taken, then draw the gap before the next one.
    task automatic send_sample(input logic [SB-1:0] v, input logic typed,
                               input median_result_t want);
        int target;
        int gap;
        beat_typed = typed;
        beat_want = want;
        in_valid <= 1'b1;
        sample_value <= v;
        target = in_beats + 1;
        wait (in_beats == target);
        if ($urandom_range(0, 15) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    initial
    begin
        int  target;
        int  stall;
        bit  take_steady;
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        take_steady = 1'b0;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                take_steady = !take_steady;
            stall = take_steady ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            target = out_beats + 1;
            wait (out_beats == target);
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        sample_value <= '0;
        kept_samples = 0;
        outstanding = 0;
        in_beats = 0;
        out_beats = 0;
        mismatches = 0;
        idle_cycles = 0;
        beat_typed = 1'b0;
        beat_want = '0;
        send_steady = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        repeat (RANDOM_N)
            send_sample(pick_sample(), 1'b0, '0);

        // Fill the store, then push past capacity.
        drain_results();
        while (in_beats < CAP)
            send_sample(pick_sample(), 1'b0, '0);
        send_sample('0, 1'b0, '0);
        send_sample('1, 1'b0, '0);
        repeat (20)
            send_sample(pick_sample(), 1'b0, '0);

        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_medians.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
